[src/qas_pkg.sv]
// Shared types, constants and helpers for the quoted argument splitter.
// No dependencies; imported by every module of the block.
package qas_pkg;

  localparam int unsigned QAS_FIFO_DEPTH = 4;
  localparam int unsigned QAS_MAX_TOKENS_RESET = 255;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_NUL       = 8'h00;

  // Scan mode, one-hot
  typedef enum logic [5:0] {
    MODE_START     = 6'b000001,
    MODE_LEADWS    = 6'b000010,
    MODE_UNQUOTED  = 6'b000100,
    MODE_QUOTED    = 6'b001000,
    MODE_BETWEEN   = 6'b010000,
    MODE_IGNORE    = 6'b100000
  } mode_t;

  // One result word (last_of_run follows from its place in the entry)
  typedef struct packed {
    logic [7:0] char_out;
    logic       has_char;
    logic       token_end;
    logic [7:0] token_index;
    logic       line_done;
    logic [7:0] token_count;
  } res_t;

  // Queue entry: all results caused by one input byte (one or two)
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } ent_t;

  // Queue status seen by the back end
  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  function automatic res_t mk_res(input logic [7:0] ch, input logic has,
                                  input logic tend, input logic [7:0] idx,
                                  input logic done, input logic [7:0] cnt);
    res_t r;
    r.char_out    = ch;
    r.has_char    = has;
    r.token_end   = tend;
    r.token_index = idx;
    r.line_done   = done;
    r.token_count = cnt;
    return r;
  endfunction

endpackage

[src/qas_front.sv]
// Front end: accepts line bytes, runs the scan state machine and builds
// one queue entry per byte that yields results. Depends on qas_pkg.
module qas_front import qas_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic       q_full,
  output logic       in_ready,
  output logic       push,
  output ent_t       push_ent
);

  mode_t      mode, mode_next;
  logic       held_bs, held_bs_next;
  logic [7:0] tokens_seen, tokens_seen_next;
  logic [7:0] max_tokens;

  logic       accept;
  logic       is_ws;
  logic       has_res;
  logic [7:0] cur_idx;
  ent_t       ent;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign cur_idx  = (tokens_seen == 8'd0) ? 8'd0 : tokens_seen - 8'd1;

  always_comb begin
    is_ws            = in_byte inside {8'd32, [8'd9:8'd13]};
    mode_next        = mode;
    held_bs_next     = held_bs;
    tokens_seen_next = tokens_seen;
    has_res          = 1'b0;
    ent.two          = 1'b0;
    ent.r0           = mk_res(CH_NUL, 1'b0, 1'b0, 8'd0, 1'b0, 8'd0);
    ent.r1           = mk_res(CH_NUL, 1'b0, 1'b0, 8'd0, 1'b0, 8'd0);

    if (in_byte == CH_NUL) begin
      // end of line: close whatever is open, report the count
      has_res = 1'b1;
      case (mode)
        MODE_LEADWS: begin
          if (tokens_seen < max_tokens) begin
            ent.r0 = mk_res(CH_NUL, 1'b0, 1'b1, tokens_seen, 1'b1,
                            tokens_seen + 8'd1);
          end else begin
            ent.r0 = mk_res(CH_NUL, 1'b0, 1'b0, 8'd0, 1'b1, tokens_seen);
          end
        end
        MODE_UNQUOTED: begin
          ent.r0 = mk_res(CH_NUL, 1'b0, 1'b1, cur_idx, 1'b1, tokens_seen);
        end
        MODE_QUOTED: begin
          if (held_bs) begin
            ent.two = 1'b1;
            ent.r0  = mk_res(CH_BACKSLASH, 1'b1, 1'b0, cur_idx, 1'b0, 8'd0);
            ent.r1  = mk_res(CH_NUL, 1'b0, 1'b1, cur_idx, 1'b1, tokens_seen);
          end else begin
            ent.r0  = mk_res(CH_NUL, 1'b0, 1'b1, cur_idx, 1'b1, tokens_seen);
          end
        end
        default: begin
          ent.r0 = mk_res(CH_NUL, 1'b0, 1'b0, 8'd0, 1'b1, tokens_seen);
        end
      endcase
      mode_next        = MODE_START;
      held_bs_next     = 1'b0;
      tokens_seen_next = 8'd0;
    end else begin
      case (mode)
        MODE_START, MODE_LEADWS, MODE_BETWEEN: begin
          if (is_ws) begin
            if (mode != MODE_BETWEEN) mode_next = MODE_LEADWS;
          end else if (tokens_seen >= max_tokens) begin
            mode_next = MODE_IGNORE;
          end else begin
            tokens_seen_next = tokens_seen + 8'd1;
            if (in_byte == CH_QUOTE) begin
              mode_next    = MODE_QUOTED;
              held_bs_next = 1'b0;
            end else begin
              mode_next = MODE_UNQUOTED;
              has_res   = 1'b1;
              ent.r0    = mk_res(in_byte, 1'b1, 1'b0, tokens_seen, 1'b0, 8'd0);
            end
          end
        end
        MODE_UNQUOTED: begin
          has_res = 1'b1;
          if (is_ws) begin
            ent.r0    = mk_res(CH_NUL, 1'b0, 1'b1, cur_idx, 1'b0, 8'd0);
            mode_next = MODE_BETWEEN;
          end else begin
            ent.r0    = mk_res(in_byte, 1'b1, 1'b0, cur_idx, 1'b0, 8'd0);
          end
        end
        MODE_QUOTED: begin
          if (held_bs) begin
            has_res = 1'b1;
            if (in_byte == CH_QUOTE) begin
              ent.r0       = mk_res(CH_QUOTE, 1'b1, 1'b0, cur_idx, 1'b0, 8'd0);
              held_bs_next = 1'b0;
            end else if (in_byte == CH_BACKSLASH) begin
              // flush the old backslash, hold the new one
              ent.r0 = mk_res(CH_BACKSLASH, 1'b1, 1'b0, cur_idx, 1'b0, 8'd0);
            end else begin
              ent.two      = 1'b1;
              ent.r0       = mk_res(CH_BACKSLASH, 1'b1, 1'b0, cur_idx, 1'b0, 8'd0);
              ent.r1       = mk_res(in_byte, 1'b1, 1'b0, cur_idx, 1'b0, 8'd0);
              held_bs_next = 1'b0;
            end
          end else if (in_byte == CH_QUOTE) begin
            has_res   = 1'b1;
            ent.r0    = mk_res(CH_NUL, 1'b0, 1'b1, cur_idx, 1'b0, 8'd0);
            mode_next = MODE_BETWEEN;
          end else if (in_byte == CH_BACKSLASH) begin
            held_bs_next = 1'b1;
          end else begin
            has_res = 1'b1;
            ent.r0  = mk_res(in_byte, 1'b1, 1'b0, cur_idx, 1'b0, 8'd0);
          end
        end
        default: begin
          // ignore state: drop the rest of the line
        end
      endcase
    end
  end

  assign push     = accept && has_res;
  assign push_ent = ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_START;
      held_bs     <= 1'b0;
      tokens_seen <= 8'd0;
      max_tokens  <= 8'(QAS_MAX_TOKENS_RESET);
    end else begin
      if (cfg_we) max_tokens <= cfg_wdata;
      if (accept) begin
        mode        <= mode_next;
        held_bs     <= held_bs_next;
        tokens_seen <= tokens_seen_next;
      end
    end
  end

endmodule

[src/qas_fifo.sv]
// Short entry queue between front and back end, register based.
// Depends on qas_pkg.
module qas_fifo import qas_pkg::*; #(
  parameter int unsigned DEPTH = QAS_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  ent_t       push_ent,
  input  logic       pop,
  output ent_t       head,
  output fifo_stat_t stat
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ent_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] cnt;
  logic          do_push, do_pop;

  assign stat.empty = (cnt == CW'(0));
  assign stat.full  = (cnt == CW'(DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem[rd_ptr];

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? AW'(0) : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_ent;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) wr_ptr <= wrap_inc(wr_ptr);
      if (do_pop)  rd_ptr <= wrap_inc(rd_ptr);
      if (do_push && !do_pop)      cnt <= cnt + CW'(1);
      else if (do_pop && !do_push) cnt <= cnt - CW'(1);
    end
  end

endmodule

[src/qas_back.sv]
// Back end: plays the head queue entry out as one or two stream words
// and pops it when its last word is taken. Depends on qas_pkg.
module qas_back import qas_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  ent_t        head,
  input  fifo_stat_t  stat,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,
  output logic [2:0]  m_tuser,
  output logic        m_tlast
);

  logic phase;   // second word of a two-word entry
  res_t cur;
  logic take;

  assign cur      = phase ? head.r1 : head.r0;
  assign m_tvalid = !stat.empty;
  assign m_tlast  = !head.two || phase;
  assign m_tdata  = {cur.token_count, cur.token_index, cur.char_out};
  assign m_tuser  = {cur.line_done, cur.token_end, cur.has_char};
  assign take     = m_tvalid && m_tready;
  assign pop      = take && m_tlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
    end else if (take) begin
      phase <= !m_tlast;
    end
  end

endmodule

[src/quoted_argument_splitter_unit.sv]
// Top level of the quoted argument splitter: front end, entry queue,
// back end. Depends on qas_pkg, qas_front, qas_fifo and qas_back.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata  = data_byte
//  m_*       out  m_tvalid/m_tready  m_tdata, m_tuser, m_tlast = one result
//  cfg_*     in   cfg_we             cfg_wdata = max_tokens
//
// One byte is taken per cycle while the queue is not full; its results
// are queued and then played out on m_*. A byte giving two words takes
// two output words, one giving none takes nothing from the back end; the
// queue depth sets how many entries may wait for a stalled consumer.
// s_tready drops only while the queue is full.
// rst is synchronous: scan mode to start of line, count and held
// backslash cleared, queue emptied, max_tokens back to 255.
module quoted_argument_splitter_unit import qas_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = QAS_FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,   // max_tokens
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,     // [7:0] data_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,     // [7:0] char_out, [15:8] token_index,
                                   // [23:16] token_count
  output logic [2:0]  m_tuser,     // [0] has_char, [1] token_end,
                                   // [2] line_done
  output logic        m_tlast      // last_of_run
);

  logic       push, pop;
  ent_t       push_ent, head;
  fifo_stat_t stat;

  // classify and scan
  qas_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_tvalid),
    .in_byte   (s_tdata),
    .q_full    (stat.full),
    .in_ready  (s_tready),
    .push      (push),
    .push_ent  (push_ent)
  );

  // decouples the two sides
  qas_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_ent (push_ent),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  // serialise entries into stream words
  qas_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .stat     (stat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

`ifndef NO_ASSERTIONS
  // end of line report always closes the byte's run
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[2]) |-> m_tlast)
    else $error("line_done word without tlast");

  // a character word never carries the end-of-line report
  a_char_not_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> !m_tuser[2])
    else $error("has_char and line_done together");

  // count field only on the end-of-line word
  a_count_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[2]) |-> (m_tdata[23:16] == 8'd0))
    else $error("token_count set without line_done");

  // queue full must stop the front end
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    stat.full |-> !s_tready)
    else $error("input ready while queue full");
`endif

endmodule
